// File: hw/rtl/stepper_trapezoid_ramp_defines.svh
// Assertion macros shared by the stepper ramp RTL.
// Used by files that sample clk and rst; no other dependencies.
`ifndef STEPPER_TRAPEZOID_RAMP_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/str_pkg.sv
// Shared types and constants for the stepper speed-ramp generator.
// Used by str_arith, stepper_trapezoid_ramp and the testbench; no dependencies.
package str_pkg;

  localparam int DW       = 40;  // dividend / product width of the serial unit
  localparam int VW       = 36;  // divisor / multiplier width of the serial unit
  localparam int MUL_BITS = 16;  // multiplier bits consumed by a multiply
  localparam int CNT_W    = 6;

  localparam logic [15:0] ONE_STEP_DELAY = 16'd1000;

  localparam logic [15:0] CRUISE_DELAY_RST = 16'd100;
  localparam logic [15:0] FIRST_DELAY_RST  = 16'd10000;
  localparam logic [23:0] SPEED_LIM_RST    = 24'd100;
  localparam logic [15:0] ACCEL_RST        = 16'd100;
  localparam logic [15:0] DECEL_RST        = 16'd100;

  localparam logic [2:0] REG_CRUISE_DELAY = 3'd0;
  localparam logic [2:0] REG_FIRST_DELAY  = 3'd1;
  localparam logic [2:0] REG_SPEED_LIM    = 3'd2;
  localparam logic [2:0] REG_ACCEL        = 3'd3;
  localparam logic [2:0] REG_DECEL        = 3'd4;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_DECEL = 2'd2,
    PH_RUN   = 2'd3
  } phase_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL1 = 7'b0000010,
    S_DIV1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_DIV2 = 7'b0010000,
    S_RAMP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic          start;
    logic          is_div;
    logic [DW-1:0] opa;
    logic [VW-1:0] opb;
  } arith_cmd_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] res;
    logic [VW-1:0] rem;
  } arith_sts_t;

endpackage

// File: hw/rtl/str_arith.sv
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// Depends on str_pkg.
module str_arith (
  input  logic                    clk,
  input  logic                    rst,
  input  str_pkg::arith_cmd_t     cmd,
  output str_pkg::arith_sts_t     sts
);

  logic                        busy;
  logic                        done;
  logic                        is_div;
  logic [str_pkg::CNT_W-1:0]   cnt;
  logic [str_pkg::DW-1:0]      a_sh;
  logic [str_pkg::VW-1:0]      b_sh;
  logic [str_pkg::DW-1:0]      acc;
  logic [str_pkg::VW-1:0]      rem;

  logic [str_pkg::VW:0]        shifted;
  logic [str_pkg::VW:0]        diff;
  logic                        qbit;

  assign shifted = {rem, a_sh[str_pkg::DW-1]};
  assign diff    = shifted - {1'b0, b_sh};
  assign qbit    = !diff[str_pkg::VW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !cmd.start && busy && (cnt == str_pkg::CNT_W'(1));
      if (cmd.start) begin
        busy   <= 1'b1;
        is_div <= cmd.is_div;
        a_sh   <= cmd.opa;
        b_sh   <= cmd.opb;
        acc    <= '0;
        rem    <= '0;
        cnt    <= cmd.is_div ? str_pkg::CNT_W'(str_pkg::DW) : str_pkg::CNT_W'(str_pkg::MUL_BITS);
      end else if (busy) begin
        if (is_div) begin
          // Quotient bits shift in at the bottom as dividend bits leave the top.
          rem  <= qbit ? diff[str_pkg::VW-1:0] : shifted[str_pkg::VW-1:0];
          a_sh <= {a_sh[str_pkg::DW-2:0], qbit};
        end else begin
          if (b_sh[0]) begin
            acc <= acc + a_sh;
          end
          a_sh <= {a_sh[str_pkg::DW-2:0], 1'b0};
          b_sh <= {1'b0, b_sh[str_pkg::VW-1:1]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == str_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.res  = is_div ? a_sh : acc;
  assign sts.rem  = rem;

endmodule

// File: hw/rtl/stepper_trapezoid_ramp.sv
// Trapezoidal stepper speed-ramp generator; uses str_pkg and str_arith.
// A start that plans a move runs two multiplies and two divides (MUL1, DIV1, MUL2, DIV2)
// before it posts its word; the input is ready again in the same cycle as the word is posted.
// A toggle that counts a step in phase ACCEL or DECEL runs one divide first; other items
// post directly. No new item is taken until the word posts; a stalled output delays it.
// Reset (rst, synchronous) loads register defaults and the STOP phase, idle.
`include "stepper_trapezoid_ramp_defines.svh"
module stepper_trapezoid_ramp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] move_steps
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  // [14:0] compare_offset, [15] direction, [16] moving, [48:17] position,
  // [80:49] pulse_total, [81] step_done, [87:82] zero
  output logic [87:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  logic [15:0] cruise_delay, first_delay, accel_rate, decel_rate;
  logic [23:0] speed_limit_steps;

  str_pkg::state_t   state;
  str_pkg::phase_t   ramp_phase;
  logic              dir_bit, active, toggle_half;
  logic [15:0]       cur_delay, last_ramp_delay;
  logic [31:0]       ramp_count, division_rest, decel_begin, decel_length;
  logic [31:0]       steps_taken, abs_position, pulse_counter;
  logic [23:0]       step_q, acc_lim_q;
  logic [14:0]       off_q;
  logic              use_now, done_q, num_neg, q_neg;

  str_pkg::arith_cmd_t ar_cmd;
  str_pkg::arith_sts_t ar_sts;

  str_arith u_arith (.clk(clk), .rst(rst), .cmd(ar_cmd), .sts(ar_sts));

  logic [15:0] a_eff, d_eff;
  logic [23:0] lim_eff, raw, step_mag;
  logic [31:0] rc_inc, dv_raw, dv;
  logic [35:0] num, den, num_mag, den_mag;
  logic        br1, dv_zero;
  logic [15:0] q_lo, nd;
  logic [31:0] r_lo;
  logic        plan_go, step_go, ramp_go;

  always_comb begin
    a_eff    = (accel_rate == 16'd0) ? 16'd1 : accel_rate;
    d_eff    = (decel_rate == 16'd0) ? 16'd1 : decel_rate;
    lim_eff  = (speed_limit_steps == 24'd0) ? 24'd1 : speed_limit_steps;
    raw      = s_tdata;
    step_mag = raw[23] ? (24'd0 - raw) : raw;
    rc_inc   = ramp_count + 32'd1;
    // Signed ramp division: num = 2*delay + rest, den = 4*(count + 1) + 1.
    num      = {19'd0, cur_delay, 1'b0} + {{4{division_rest[31]}}, division_rest};
    den      = {{2{rc_inc[31]}}, rc_inc, 2'b01};
    num_mag  = num[35] ? (36'd0 - num) : num;
    den_mag  = den[35] ? (36'd0 - den) : den;
    q_lo     = q_neg ? (16'd0 - ar_sts.res[15:0]) : ar_sts.res[15:0];
    r_lo     = num_neg ? (32'd0 - ar_sts.rem[31:0]) : ar_sts.rem[31:0];
    nd       = cur_delay - q_lo;
    br1      = acc_lim_q <= lim_eff;
    dv_raw   = br1 ? ({8'd0, acc_lim_q} - {8'd0, step_q}) : (32'd0 - ar_sts.res[31:0]);
    dv_zero  = br1 ? (acc_lim_q == step_q) : (ar_sts.res == '0);
    dv       = dv_zero ? 32'hFFFF_FFFF : dv_raw;
    // A start of two or more steps while inactive needs the planning arithmetic.
    plan_go  = !s_tuser && !active && (step_mag != 24'd0) && (step_mag != 24'd1);
    // The second toggle of a step counts it unless the phase is STOP.
    step_go  = s_tuser && active && toggle_half && (ramp_phase != str_pkg::PH_STOP);
    ramp_go  = step_go && (ramp_phase != str_pkg::PH_RUN);
  end

  assign s_tready = (state == str_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_delay      <= str_pkg::CRUISE_DELAY_RST;
      first_delay       <= str_pkg::FIRST_DELAY_RST;
      speed_limit_steps <= str_pkg::SPEED_LIM_RST;
      accel_rate        <= str_pkg::ACCEL_RST;
      decel_rate        <= str_pkg::DECEL_RST;
      state             <= str_pkg::S_IDLE;
      ramp_phase        <= str_pkg::PH_STOP;
      dir_bit           <= 1'b0;
      active            <= 1'b0;
      toggle_half       <= 1'b0;
      cur_delay         <= '0;
      ramp_count        <= '0;
      division_rest     <= '0;
      decel_begin       <= '0;
      decel_length      <= '0;
      steps_taken       <= '0;
      last_ramp_delay   <= '0;
      abs_position      <= '0;
      pulse_counter     <= '0;
      m_tvalid          <= 1'b0;
      ar_cmd.start      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          str_pkg::REG_CRUISE_DELAY: cruise_delay      <= cfg_data[15:0];
          str_pkg::REG_FIRST_DELAY:  first_delay       <= cfg_data[15:0];
          str_pkg::REG_SPEED_LIM:    speed_limit_steps <= cfg_data;
          str_pkg::REG_ACCEL:        accel_rate        <= cfg_data[15:0];
          str_pkg::REG_DECEL:        decel_rate        <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != str_pkg::S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        str_pkg::S_IDLE: begin
          ar_cmd.start <= s_tvalid && (plan_go || ramp_go);
          if (s_tvalid) begin
            off_q   <= cur_delay[15:1];
            use_now <= !s_tuser;
            done_q  <= step_go;
            if (plan_go) begin
              state <= str_pkg::S_MUL1;
            end else if (ramp_go) begin
              state <= str_pkg::S_RAMP;
            end else begin
              state <= str_pkg::S_OUT;
            end
            if (!s_tuser) begin
              if (!active) begin
                dir_bit <= raw[23];
                active  <= 1'b1;
                if (step_mag == 24'd1) begin
                  ramp_count <= 32'hFFFF_FFFF;
                  ramp_phase <= str_pkg::PH_DECEL;
                  cur_delay  <= str_pkg::ONE_STEP_DELAY;
                end else if (step_mag != 24'd0) begin
                  step_q        <= step_mag;
                  ar_cmd.is_div <= 1'b0;
                  ar_cmd.opa    <= {16'd0, step_mag};
                  ar_cmd.opb    <= {20'd0, d_eff};
                end
              end
            end else if (active) begin
              toggle_half <= !toggle_half;
              if (toggle_half) begin
                if (ramp_phase == str_pkg::PH_STOP) begin
                  steps_taken   <= '0;
                  division_rest <= '0;
                  active        <= 1'b0;
                  cur_delay     <= '0;
                end else begin
                  pulse_counter <= pulse_counter + 32'd1;
                  steps_taken   <= steps_taken + 32'd1;
                  abs_position  <= dir_bit ? abs_position - 32'd1 : abs_position + 32'd1;
                  if (ramp_phase == str_pkg::PH_RUN) begin
                    if (steps_taken + 32'd1 >= decel_begin) begin
                      ramp_count <= decel_length;
                      cur_delay  <= last_ramp_delay;
                      ramp_phase <= str_pkg::PH_DECEL;
                    end else begin
                      cur_delay <= cruise_delay;
                    end
                  end else begin
                    ramp_count    <= rc_inc;
                    num_neg       <= num[35];
                    q_neg         <= num[35] ^ den[35];
                    ar_cmd.is_div <= 1'b1;
                    ar_cmd.opa    <= {4'd0, num_mag};
                    ar_cmd.opb    <= den_mag;
                  end
                end
              end
            end
          end
        end
        str_pkg::S_MUL1: begin
          ar_cmd.start <= ar_sts.done;
          if (ar_sts.done) begin
            ar_cmd.is_div <= 1'b1;
            ar_cmd.opa    <= ar_sts.res;
            ar_cmd.opb    <= {19'd0, {1'b0, a_eff} + {1'b0, d_eff}};
            state         <= str_pkg::S_DIV1;
          end
        end
        str_pkg::S_DIV1: begin
          ar_cmd.start <= ar_sts.done;
          if (ar_sts.done) begin
            acc_lim_q     <= (ar_sts.res[23:0] == 24'd0) ? 24'd1 : ar_sts.res[23:0];
            ar_cmd.is_div <= 1'b0;
            ar_cmd.opa    <= {16'd0, lim_eff};
            ar_cmd.opb    <= {20'd0, a_eff};
            state         <= str_pkg::S_MUL2;
          end
        end
        str_pkg::S_MUL2: begin
          ar_cmd.start <= ar_sts.done;
          if (ar_sts.done) begin
            ar_cmd.is_div <= 1'b1;
            ar_cmd.opa    <= ar_sts.res;
            ar_cmd.opb    <= {20'd0, d_eff};
            state         <= str_pkg::S_DIV2;
          end
        end
        str_pkg::S_DIV2: begin
          ar_cmd.start <= 1'b0;
          if (ar_sts.done) begin
            decel_length <= dv;
            decel_begin  <= {8'd0, step_q} + dv;
            ramp_count   <= '0;
            if (first_delay <= cruise_delay) begin
              cur_delay  <= cruise_delay;
              ramp_phase <= str_pkg::PH_RUN;
            end else begin
              cur_delay  <= first_delay;
              ramp_phase <= str_pkg::PH_ACCEL;
            end
            state <= str_pkg::S_OUT;
          end
        end
        str_pkg::S_RAMP: begin
          ar_cmd.start <= 1'b0;
          if (ar_sts.done) begin
            if (ramp_phase == str_pkg::PH_ACCEL) begin
              if (steps_taken >= decel_begin) begin
                cur_delay     <= nd;
                division_rest <= r_lo;
                ramp_count    <= decel_length;
                ramp_phase    <= str_pkg::PH_DECEL;
              end else if (nd <= cruise_delay) begin
                last_ramp_delay <= nd;
                cur_delay       <= cruise_delay;
                division_rest   <= '0;
                ramp_phase      <= str_pkg::PH_RUN;
              end else begin
                cur_delay     <= nd;
                division_rest <= r_lo;
              end
            end else begin
              cur_delay     <= nd;
              division_rest <= r_lo;
              if (!ramp_count[31]) begin
                ramp_phase <= str_pkg::PH_STOP;
              end
            end
            state <= str_pkg::S_OUT;
          end
        end
        str_pkg::S_OUT: begin
          ar_cmd.start <= 1'b0;
          // Wait for the output register to be free, then post the word.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, done_q, pulse_counter, abs_position, active, dir_bit,
                         (use_now ? cur_delay[15:1] : off_q)};
            state    <= str_pkg::S_IDLE;
          end
        end
        default: begin
          ar_cmd.start <= 1'b0;
          state        <= str_pkg::S_IDLE;
        end
      endcase
    end
  end

  `STR_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state), "state not one-hot")
  `STR_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready,
                   state != str_pkg::S_IDLE, "accepted word left block idle")
  `STR_ASSERT_SAME(a_done_in_arith, ar_sts.done,
                   state != str_pkg::S_IDLE && state != str_pkg::S_OUT,
                   "serial unit finished outside an arithmetic state")
  `STR_ASSERT_SAME(a_step_while_moving, m_tvalid && m_tdata[81], m_tdata[16],
                   "step reported while not moving")
  `STR_ASSERT_SAME(a_idle_half_clear, !active, !toggle_half, "toggle phase set while idle")

endmodule

// File: tb/tb_stepper_trapezoid_ramp.sv
// Self-checking testbench for the trapezoidal stepper speed-ramp generator.
// Depends on str_pkg and stepper_trapezoid_ramp; a local predictor checks every result word.
`timescale 1ns / 100ps
module tb_stepper_trapezoid_ramp;

  localparam bit OP_START  = 1'b0;
  localparam bit OP_TOGGLE = 1'b1;

  typedef struct {
    logic [14:0] offset;
    logic        dir;
    logic        moving;
    logic [31:0] pos;
    logic [31:0] pulses;
    logic        done;
  } ramp_out_t;

  typedef struct {
    bit          op;
    logic [23:0] steps;
    bit          typed;
    ramp_out_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int items_sent;

  ramp_out_t expected_words[$];

  // Predictor copy of the registers and the ramp state.
  logic [15:0] p_cruise_delay, p_first_delay, p_accel, p_decel;
  logic [23:0] p_speed_lim;
  str_pkg::phase_t p_phase;
  logic        p_dir, p_active, p_half;
  logic [15:0] p_delay, p_last_ramp;
  logic [31:0] p_rcount, p_rest, p_dbegin, p_dlen, p_taken, p_pos, p_pulses;

  stepper_trapezoid_ramp i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  function void reset_model();
    p_cruise_delay = str_pkg::CRUISE_DELAY_RST; p_first_delay = str_pkg::FIRST_DELAY_RST;
    p_speed_lim = str_pkg::SPEED_LIM_RST; p_accel = str_pkg::ACCEL_RST;
    p_decel = str_pkg::DECEL_RST;
    p_phase = str_pkg::PH_STOP; p_dir = 0; p_active = 0; p_half = 0; p_delay = 0;
    p_rcount = 0; p_rest = 0; p_dbegin = 0; p_dlen = 0; p_taken = 0;
    p_last_ramp = 0; p_pos = 0; p_pulses = 0;
  endfunction

  // New delay by signed division; the remainder is carried to the next step.
  function logic [15:0] ramp_next_delay();
    longint num, den, q, r;
    num = 2 * longint'(p_delay) + longint'(signed'(p_rest));
    den = 4 * longint'(signed'(p_rcount)) + 1;
    q = num / den;
    r = num % den;
    p_rest = r[31:0];
    return p_delay - q[15:0];
  endfunction

  function void count_pulse();
    p_pulses++;
    p_taken++;
    p_pos = p_dir ? p_pos - 1 : p_pos + 1;
  endfunction

  function void plan_move(input logic [23:0] raw);
    longint unsigned stp, a, d, lim, acc_lim;
    longint dv;
    p_dir = raw[23];
    stp = raw[23] ? 64'h100_0000 - raw : raw;
    if (stp == 1) begin
      p_rcount = 32'hFFFF_FFFF;
      p_phase = str_pkg::PH_DECEL;
      p_delay = str_pkg::ONE_STEP_DELAY;
    end else if (stp != 0) begin
      a = p_accel ? p_accel : 1;
      d = p_decel ? p_decel : 1;
      lim = p_speed_lim ? p_speed_lim : 1;
      acc_lim = stp * d / (a + d);
      if (acc_lim == 0) acc_lim = 1;
      if (acc_lim <= lim) dv = longint'(acc_lim) - longint'(stp);
      else dv = -longint'(lim * a / d);
      if (dv == 0) dv = -1;
      p_dlen = dv[31:0];
      p_dbegin = 32'(stp + dv);
      p_delay = p_first_delay;
      if (p_delay <= p_cruise_delay) begin
        p_delay = p_cruise_delay;
        p_phase = str_pkg::PH_RUN;
      end else begin
        p_phase = str_pkg::PH_ACCEL;
      end
      p_rcount = 0;
    end
    p_active = 1;
  endfunction

  function ramp_out_t predict_word(input bit op, input logic [23:0] steps);
    ramp_out_t   res;
    logic [15:0] nd;
    res.done = 0;
    nd = 0;
    if (op == OP_START) begin
      if (!p_active) plan_move(steps);
      res.offset = p_delay[15:1];
    end else begin
      res.offset = p_delay[15:1];
      if (p_active) begin
        p_half = ~p_half;
        if (!p_half) begin
          case (p_phase)
            str_pkg::PH_STOP: begin
              p_taken = 0;
              p_rest = 0;
              p_active = 0;
            end
            str_pkg::PH_ACCEL: begin
              count_pulse(); res.done = 1;
              p_rcount++;
              nd = ramp_next_delay();
              if (p_taken >= p_dbegin) begin
                p_rcount = p_dlen;
                p_phase = str_pkg::PH_DECEL;
              end else if (nd <= p_cruise_delay) begin
                p_last_ramp = nd;
                nd = p_cruise_delay;
                p_rest = 0;
                p_phase = str_pkg::PH_RUN;
              end
            end
            str_pkg::PH_RUN: begin
              count_pulse(); res.done = 1;
              nd = p_cruise_delay;
              if (p_taken >= p_dbegin) begin
                p_rcount = p_dlen;
                nd = p_last_ramp;
                p_phase = str_pkg::PH_DECEL;
              end
            end
            default: begin
              count_pulse(); res.done = 1;
              p_rcount++;
              nd = ramp_next_delay();
              if (signed'(p_rcount) >= 0) p_phase = str_pkg::PH_STOP;
            end
          endcase
          p_delay = nd;
        end
      end
    end
    res.dir = p_dir;
    res.moving = p_active;
    res.pos = p_pos;
    res.pulses = p_pulses;
    return res;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the word.
  task send_word(input bit op, input logic [23:0] steps, input bit typed, input ramp_out_t want);
    bit        took;
    ramp_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= steps;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    res = predict_word(op, steps);
    expected_words.push_back(typed ? want : res);
    items_sent++;
  endtask

  task send_plain(input bit op, input logic [23:0] steps);
    ramp_out_t none;
    none = '{default: 0};
    send_word(op, steps, 1'b0, none);
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      str_pkg::REG_CRUISE_DELAY: p_cruise_delay = value[15:0];
      str_pkg::REG_FIRST_DELAY:  p_first_delay = value[15:0];
      str_pkg::REG_SPEED_LIM:    p_speed_lim = value;
      str_pkg::REG_ACCEL:        p_accel = value[15:0];
      str_pkg::REG_DECEL:        p_decel = value[15:0];
      default: ;
    endcase
  endtask

  // Toggle until the move has wound down, with ignored starts mixed in.
  task finish_move();
    while (p_active) begin
      if ($urandom_range(11) == 0) send_plain(OP_START, 24'($urandom));
      else send_plain(OP_TOGGLE, 24'($urandom));
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    ramp_out_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
      end else begin
        w = expected_words.pop_front();
        if (m_tdata[14:0] !== w.offset) report_mismatch("compare_offset", m_tdata[14:0], w.offset);
        if (m_tdata[15] !== w.dir) report_mismatch("direction", m_tdata[15], w.dir);
        if (m_tdata[16] !== w.moving) report_mismatch("moving", m_tdata[16], w.moving);
        if (m_tdata[48:17] !== w.pos) report_mismatch("position", m_tdata[48:17], w.pos);
        if (m_tdata[80:49] !== w.pulses) report_mismatch("pulse_total", m_tdata[80:49], w.pulses);
        if (m_tdata[81] !== w.done) report_mismatch("step_done", m_tdata[81], w.done);
      end
    end
  end

  stim_row_t directed[25];
  int        target;
  int        mag;
  logic [23:0] steps;

  initial begin
    errors = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    reset_model();

    for (int i = 0; i < 25; i++) directed[i] = '{OP_TOGGLE, 24'h0, 1'b0, '{default: 0}};
    // Toggle while idle right after reset: everything reads zero.
    directed[0] = '{OP_TOGGLE, 24'h0, 1'b1, '{15'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0}};
    // One-step move uses the fixed delay of 1000 ticks.
    directed[1] = '{OP_START, 24'd1, 1'b1, '{15'd500, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0}};
    // Start while moving is ignored.
    directed[2] = '{OP_START, -24'sd5, 1'b1, '{15'd500, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0}};
    directed[7] = '{OP_START, -24'sd1, 1'b0, '{default: 0}};
    directed[12] = '{OP_START, 24'd0, 1'b0, '{default: 0}};
    directed[16] = '{OP_START, 24'd3, 1'b0, '{default: 0}};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i].op, directed[i].steps,
                                    directed[i].typed, directed[i].want);
    finish_move();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (ph == 1) begin
        write_reg(str_pkg::REG_CRUISE_DELAY, 24'hFFFF);
        write_reg(str_pkg::REG_FIRST_DELAY, 24'hFFFF);
        write_reg(str_pkg::REG_SPEED_LIM, 24'hFF_FFFF);
        write_reg(str_pkg::REG_ACCEL, 24'hFFFF);
        write_reg(str_pkg::REG_DECEL, 24'hFFFF);
      end else if (ph == 2) begin
        write_reg(str_pkg::REG_CRUISE_DELAY, 24'd1);
        write_reg(str_pkg::REG_FIRST_DELAY, 24'd1);
        write_reg(str_pkg::REG_SPEED_LIM, 24'd0);
        write_reg(str_pkg::REG_ACCEL, 24'd1);
        write_reg(str_pkg::REG_DECEL, 24'd1);
      end else if (ph != 0) begin
        write_reg(str_pkg::REG_CRUISE_DELAY, 24'($urandom_range(3000, 1)));
        write_reg(str_pkg::REG_FIRST_DELAY, 24'($urandom_range(65535, 1)));
        write_reg(str_pkg::REG_SPEED_LIM, 24'($urandom_range(60)));
        write_reg(str_pkg::REG_ACCEL, 24'($urandom_range(65535, 1)));
        write_reg(str_pkg::REG_DECEL, 24'($urandom_range(65535, 1)));
      end
      target = items_sent + 95;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) mag = $urandom_range(1);
        else mag = $urandom_range(40, 2);
        steps = $urandom_range(1) ? -24'(mag) : 24'(mag);
        send_plain(OP_START, steps);
        finish_move();
        if ($urandom_range(3) == 0) send_plain(OP_TOGGLE, 24'($urandom));
      end
      wait_drained();
    end

    // Counts of magnitude 0x7FFFFF in both directions; the move is left running at the end.
    send_plain(OP_START, 24'h80_0001);
    repeat (6) send_plain(OP_TOGGLE, 24'h0);
    send_plain(OP_START, 24'h7F_FFFF);
    wait_drained();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
